// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  // Input transaction: one byte of the buffer
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } utf8d_in_t;

  // Output transaction: a code point or the end-of-buffer item
  typedef struct packed {
    logic [20:0] scalar_value;
    logic        end_of_buffer;
    logic        invalid;
    logic [15:0] point_count;
  } utf8d_out_t;

  // Largest point count the application asks for
  localparam longint unsigned MAX_POINTS = 65535;

  // Saturation point of the decoded point count
  localparam logic [15:0] COUNT_LIMIT =
    (MAX_POINTS > 64'd65535) ? 16'hFFFF : 16'(MAX_POINTS);

  // Range limits of the scalar values
  localparam logic [20:0] CP_MIN_2      = 21'h00_0080;
  localparam logic [20:0] CP_MAX_2      = 21'h00_07FF;
  localparam logic [20:0] CP_MIN_3      = 21'h00_0800;
  localparam logic [20:0] CP_MAX_3      = 21'h00_FFFF;
  localparam logic [20:0] CP_SURR_LO    = 21'h00_D800;
  localparam logic [20:0] CP_SURR_HI    = 21'h00_DFFF;
  localparam logic [20:0] CP_MAX_SCALAR = 21'h10_FFFF;

  // Sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_ONE  = 3'd1;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

endpackage

// ===== sv/utf8d_decode.sv =====
module utf8d_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  utf8d_pkg::utf8d_in_t item_i,
  output logic [1:0]           push_cnt_o,
  output utf8d_pkg::utf8d_out_t res0_o,
  output utf8d_pkg::utf8d_out_t res1_o
);
  import utf8d_pkg::*;

  logic [1:0]  bp_q, bp_d;
  logic [2:0]  seq_q, seq_d;
  logic [20:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  b;
  logic        done;
  logic        bad;
  logic        emit;
  utf8d_out_t  cp_item;
  utf8d_out_t  end_item;

  assign b = item_i.in_byte;

  // Decode one byte against the sequence state
  always_comb begin
    bp_d  = bp_q;
    seq_d = seq_q;
    acc_d = acc_q;
    err_d = err_q;
    cnt_d = cnt_q;
    done  = 1'b0;
    bad   = 1'b0;
    emit  = 1'b0;

    if (!err_q) begin
      if (bp_q == 2'd0) begin
        if (b[7] == 1'b0) begin
          acc_d = {13'd0, b};
          seq_d = SEQ_ONE;
          done  = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          acc_d = {16'd0, b[4:0]};
          seq_d = SEQ_TWO;
          bp_d  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_d = {17'd0, b[3:0]};
          seq_d = SEQ_THREE;
          bp_d  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          acc_d = {18'd0, b[2:0]};
          seq_d = SEQ_FOUR;
          bp_d  = 2'd3;
        end else begin
          err_d = 1'b1;
          bp_d  = 2'd0;
          seq_d = SEQ_NONE;
          acc_d = '0;
        end
      end else if (b[7:6] != 2'b10) begin
        err_d = 1'b1;
        bp_d  = 2'd0;
        seq_d = SEQ_NONE;
        acc_d = '0;
      end else begin
        acc_d = {acc_q[14:0], b[5:0]};
        bp_d  = bp_q - 2'd1;
        done  = (bp_q == 2'd1);
      end
    end

    // Range check on a completed sequence
    if (done) begin
      case (seq_d)
        SEQ_TWO:   bad = (acc_d < CP_MIN_2) || (acc_d > CP_MAX_2);
        SEQ_THREE: bad = (acc_d < CP_MIN_3) || (acc_d > CP_MAX_3) ||
                         ((acc_d >= CP_SURR_LO) && (acc_d <= CP_SURR_HI));
        SEQ_FOUR:  bad = (acc_d <= CP_MAX_3) || (acc_d > CP_MAX_SCALAR);
        default:   bad = 1'b0;
      endcase
    end

    cp_item = '{scalar_value: acc_d, end_of_buffer: 1'b0, invalid: 1'b0,
                point_count: 16'd0};

    if (done) begin
      if (bad) begin
        err_d = 1'b1;
        bp_d  = 2'd0;
        seq_d = SEQ_NONE;
        acc_d = '0;
      end else begin
        emit  = 1'b1;
        if (cnt_q < COUNT_LIMIT) begin
          cnt_d = cnt_q + 16'd1;
        end
        seq_d = SEQ_NONE;
        acc_d = '0;
      end
    end

    // Truncated sequence at the end of the buffer
    if (item_i.last_byte && !err_d && (bp_d != 2'd0)) begin
      err_d = 1'b1;
    end

    end_item = '{scalar_value: 21'd0, end_of_buffer: 1'b1, invalid: err_d,
                 point_count: err_d ? 16'd0 : cnt_d};

    // Return to the idle state for the next buffer
    if (item_i.last_byte) begin
      bp_d  = 2'd0;
      seq_d = SEQ_NONE;
      acc_d = '0;
      err_d = 1'b0;
      cnt_d = '0;
    end
  end

  // Order results: code point first, then the end item
  always_comb begin
    push_cnt_o = {1'b0, emit} + {1'b0, item_i.last_byte};
    res0_o     = emit ? cp_item : end_item;
    res1_o     = end_item;
  end

  // Hold the decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q  <= '0;
      seq_q <= SEQ_NONE;
      acc_q <= '0;
      err_q <= 1'b0;
      cnt_q <= '0;
    end else if (step_i) begin
      bp_q  <= bp_d;
      seq_q <= seq_d;
      acc_q <= acc_d;
      err_q <= err_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/utf8d_outq.sv =====
module utf8d_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_cnt_i,
  input  utf8d_pkg::utf8d_out_t push0_i,
  input  utf8d_pkg::utf8d_out_t push1_i,
  output logic                  room2_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8d_pkg::utf8d_out_t out_data_o
);
  import utf8d_pkg::*;

  utf8d_out_t  mem_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;
  logic        pop;
  logic [1:0]  wr_ptr_nxt;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= 3'd2);
  assign wr_ptr_nxt  = wr_ptr_q + 2'd1;

  // Store up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_cnt_i;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push_cnt_i} - {2'b00, pop};
    end
  end

endmodule

// ===== sv/utf8_to_utf32_decoder.sv =====
// UTF-8 to UTF-32 decoder with validation.
// Input channel: one byte per transaction (in_data_i.in_byte), with
// in_data_i.last_byte set on the final byte of a buffer.
// Output channel: one result per transaction. A code point item carries the
// scalar value with end_of_buffer low. The final byte of a buffer adds an
// end item with end_of_buffer high, the invalid flag and the saturating
// count of decoded points (zero when invalid). Malformed input stops code
// point output until the end of that buffer.
// Throughput: one byte per cycle. A final byte that also completes a code
// point yields two results, which drain at one per cycle through a
// four-entry result queue; input is taken while the queue has room for two.
// Each byte passes through the input register, and its results through
// the result queue, before they can be taken by the receiver.
// Reset clears the decoder state and empties the queue. When the receiver
// stalls, results wait in the queue; input stalls without room for two.
module utf8_to_utf32_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  utf8d_pkg::utf8d_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8d_pkg::utf8d_out_t out_data_o
);
  import utf8d_pkg::*;

  utf8d_in_t  in_q;
  logic       in_valid_q;
  logic       room2;
  logic       step;
  logic [1:0] dec_cnt;
  logic [1:0] push_cnt;
  utf8d_out_t res0, res1;

  assign step       = in_valid_q && room2;
  assign in_ready_o = !in_valid_q || step;
  assign push_cnt   = step ? dec_cnt : 2'd0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  utf8d_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .push_cnt_o (dec_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  utf8d_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/utf8d_checker.sv =====
module utf8d_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input utf8d_pkg::utf8d_in_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input utf8d_pkg::utf8d_out_t out_data_o
);
  import utf8d_pkg::*;

  // Hold a waiting input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("waiting input changed");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // End items carry no code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_buffer |-> out_data_o.scalar_value == 21'd0)
    else $error("end item with nonzero code point");

  // Malformed buffers report a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_buffer && out_data_o.invalid
      |-> out_data_o.point_count == 16'd0)
    else $error("invalid end item with nonzero count");

  // Code point items are clean scalar values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_of_buffer
      |-> !out_data_o.invalid && out_data_o.point_count == 16'd0 &&
          out_data_o.scalar_value <= CP_MAX_SCALAR &&
          (out_data_o.scalar_value < CP_SURR_LO ||
           out_data_o.scalar_value > CP_SURR_HI))
    else $error("malformed code point item");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_utf8d_checker (.*);

// ===== bench/tb_utf8_to_utf32_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_to_utf32_decoder;
  import utf8d_pkg::*;

  // Tracks the decoder state, predicts the results of each accepted byte and
  // checks the results coming out of the block against them in order.
  class utf8_decode_scoreboard;
    logic [1:0]  cont_left  = '0;
    logic [2:0]  seq_len    = SEQ_NONE;
    logic [20:0] acc        = '0;
    logic        err_seen   = 1'b0;
    logic [15:0] point_cnt  = '0;
    utf8d_out_t  due_results_q[$];
    int          mismatches = 0;
    int          n_bytes    = 0;
    int          n_points   = 0;
    int          n_buffers  = 0;
    int          n_invalid  = 0;

    function new();
    endfunction

    // Print one line per mismatch and count it
    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
    endtask

    function void abort_seq();
      err_seen  = 1'b1;
      cont_left = '0;
      seq_len   = SEQ_NONE;
      acc       = '0;
    endfunction

    // Advance the decoder state by one byte and queue the results it causes
    function void decode_byte(utf8d_in_t item);
      logic [7:0] b;
      logic       done;
      logic       bad;
      utf8d_out_t r;
      b    = item.in_byte;
      done = 1'b0;
      bad  = 1'b0;
      n_bytes++;
      if (!err_seen) begin
        if (cont_left == 2'd0) begin
          if (!b[7]) begin
            acc     = {13'd0, b};
            seq_len = SEQ_ONE;
            done    = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            acc       = {16'd0, b[4:0]};
            seq_len   = SEQ_TWO;
            cont_left = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            acc       = {17'd0, b[3:0]};
            seq_len   = SEQ_THREE;
            cont_left = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            acc       = {18'd0, b[2:0]};
            seq_len   = SEQ_FOUR;
            cont_left = 2'd3;
          end else begin
            abort_seq();
          end
        end else if (b[7:6] != 2'b10) begin
          abort_seq();
        end else begin
          acc       = {acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          done      = (cont_left == 2'd0);
        end
      end

      // Range checks once a sequence completes
      if (done) begin
        case (seq_len)
          SEQ_TWO:   bad = (acc < CP_MIN_2) || (acc > CP_MAX_2);
          SEQ_THREE: bad = (acc < CP_MIN_3) || (acc > CP_MAX_3) ||
                           ((acc >= CP_SURR_LO) && (acc <= CP_SURR_HI));
          SEQ_FOUR:  bad = (acc <= CP_MAX_3) || (acc > CP_MAX_SCALAR);
          default:   bad = 1'b0;
        endcase
        if (bad) begin
          abort_seq();
        end else begin
          r = '0;
          r.scalar_value = acc;
          due_results_q.push_back(r);
          n_points++;
          if (point_cnt < COUNT_LIMIT) point_cnt++;
          seq_len = SEQ_NONE;
          acc     = '0;
        end
      end

      // End of buffer: flag a cut-off sequence, emit the status, start over
      if (item.last_byte) begin
        if (!err_seen && cont_left != 2'd0) abort_seq();
        r = '0;
        r.end_of_buffer = 1'b1;
        r.invalid       = err_seen;
        r.point_count   = err_seen ? 16'd0 : point_cnt;
        due_results_q.push_back(r);
        n_buffers++;
        if (err_seen) n_invalid++;
        cont_left = '0;
        seq_len   = SEQ_NONE;
        acc       = '0;
        err_seen  = 1'b0;
        point_cnt = '0;
      end
    endfunction

    // Compare one result transaction with the oldest prediction
    task check_result(utf8d_out_t got);
      utf8d_out_t want;
      if (due_results_q.size() == 0) begin
        report_mismatch("unexpected result, scalar_value", 32'(got.scalar_value), 32'd0);
        return;
      end
      want = due_results_q.pop_front();
      if (got.scalar_value !== want.scalar_value)
        report_mismatch("scalar_value", 32'(got.scalar_value), 32'(want.scalar_value));
      if (got.end_of_buffer !== want.end_of_buffer)
        report_mismatch("end_of_buffer", 32'(got.end_of_buffer),
                        32'(want.end_of_buffer));
      if (got.invalid !== want.invalid)
        report_mismatch("invalid", 32'(got.invalid), 32'(want.invalid));
      if (got.point_count !== want.point_count)
        report_mismatch("point_count", 32'(got.point_count), 32'(want.point_count));
    endtask

    task check_leftovers();
      if (due_results_q.size() != 0)
        report_mismatch("results never delivered", 32'(due_results_q.size()), 32'd0);
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  utf8d_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  utf8d_out_t out_data_o;

  utf8_decode_scoreboard sb = new();

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_left      = 0;
  logic [7:0] buf_q[$];

  utf8_to_utf32_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: check each result transaction, then pick ready for next cycle
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, last_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
    sb.decode_byte(in_data_i);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++)
      send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    for (int i = 0; i < 50000 && sb.due_results_q.size() != 0; i++)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [20:0] seq_floor(int len);
    case (len)
      2:       return CP_MIN_2;
      3:       return CP_MIN_3;
      4:       return CP_MAX_3 + 21'd1;
      default: return '0;
    endcase
  endfunction

  // Append the encoding of cp in len bytes, whether or not it is legal
  function automatic void push_seq(logic [20:0] cp, int len);
    case (len)
      1: buf_q.push_back({1'b0, cp[6:0]});
      2: begin
        buf_q.push_back({3'b110, cp[10:6]});
        buf_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        buf_q.push_back({4'b1110, cp[15:12]});
        buf_q.push_back({2'b10, cp[11:6]});
        buf_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        buf_q.push_back({5'b11110, cp[20:18]});
        buf_q.push_back({2'b10, cp[17:12]});
        buf_q.push_back({2'b10, cp[11:6]});
        buf_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Legal scalar value for a sequence length, leaning toward range edges
  function automatic logic [20:0] legal_cp(int len);
    logic [20:0] lo;
    logic [20:0] hi;
    lo = seq_floor(len);
    case (len)
      1:       hi = 21'h7F;
      2:       hi = CP_MAX_2;
      3:       hi = CP_MAX_3;
      default: hi = CP_MAX_SCALAR;
    endcase
    if (len == 3) begin
      if ($urandom_range(1) == 0) hi = CP_SURR_LO - 21'd1;
      else lo = CP_SURR_HI + 21'd1;
    end
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return 21'($urandom_range(hi, lo));
    endcase
  endfunction

  // Build one buffer: mostly well-formed text, some with broken sequences
  function automatic void build_random_buffer();
    logic       clean;
    int         n;
    int         pick;
    int         len;
    int         start;
    logic [7:0] b;
    buf_q.delete();
    clean = ($urandom_range(99) < 55);
    n = $urandom_range(10, 1);
    for (int i = 0; i < n; i++) begin
      pick  = clean ? 0 : $urandom_range(99);
      len   = $urandom_range(4, 1);
      start = buf_q.size();
      if (pick < 70) begin
        push_seq(legal_cp(len), len);
      end else if (pick < 76) begin
        // overlong form
        len = $urandom_range(4, 2);
        push_seq(21'($urandom_range(seq_floor(len) - 1, 0)), len);
      end else if (pick < 80) begin
        push_seq(21'($urandom_range(CP_SURR_HI, CP_SURR_LO)), 3);
      end else if (pick < 84) begin
        push_seq(21'($urandom_range(21'h1F_FFFF, CP_MAX_SCALAR + 21'd1)), 4);
      end else if (pick < 89) begin
        // sequence cut short, next byte breaks it
        len = $urandom_range(4, 2);
        push_seq(legal_cp(len), len);
        repeat ($urandom_range(len - 1, 1)) void'(buf_q.pop_back());
      end else if (pick < 93) begin
        // non-continuation byte inside a sequence
        len = $urandom_range(4, 2);
        push_seq(legal_cp(len), len);
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        buf_q[start + $urandom_range(len - 1, 1)] = b;
      end else if (pick < 97) begin
        buf_q.push_back(8'($urandom_range(255)));
      end else if ($urandom_range(1) == 0) begin
        buf_q.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      end else begin
        buf_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end
    end
    // buffer ending inside a sequence
    if (!clean && $urandom_range(99) < 15) begin
      len = $urandom_range(4, 2);
      push_seq(legal_cp(len), len);
      repeat ($urandom_range(len - 1, 1)) void'(buf_q.pop_back());
    end
  endfunction

  task automatic run_random(input int target);
    int start;
    start = sb.n_bytes;
    while (sb.n_bytes - start < target) begin
      build_random_buffer();
      send_buffer();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range edges of each length, final byte completing a point
    buf_q = '{8'h00, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
              8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_buffer();
    // overlong two-byte form
    buf_q = '{8'hC1, 8'hBF};
    send_buffer();
    // surrogate, then bytes swallowed after the error
    buf_q = '{8'hED, 8'hA0, 8'h80, 8'h41};
    send_buffer();
    // above the last scalar value
    buf_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_buffer();
    // stray continuation byte
    buf_q = '{8'h80};
    send_buffer();
    // illegal lead byte
    buf_q = '{8'hFF};
    send_buffer();
    // sequence cut off by the end of the buffer
    buf_q = '{8'hE2, 8'h82};
    send_buffer();
    drain();

    // No idling; long output hold-off while input keeps coming
    hold_left = 300;
    run_random(480);
    drain();

    send_idle_pct  = 81;
    recv_stall_pct = 0;
    run_random(480);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 81;
    run_random(480);
    drain();

    send_idle_pct  = 37;
    recv_stall_pct = 37;
    run_random(480);
    drain();

    sb.check_leftovers();
    $display("sent %0d bytes in %0d buffers: %0d code points, %0d malformed",
             sb.n_bytes, sb.n_buffers, sb.n_points, sb.n_invalid);
    $display("covered range edges, every error kind, output hold-off and four idle mixes");
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
